@@ hw/rtl/mbrtu_pkg.sv @@
`default_nettype none

package mbrtu_pkg;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_SLAVE_ADDRESS   = 2'd0;
    localparam cfg_index_t REG_EXPECTED_COUNT  = 2'd1;

    localparam logic       KIND_BODY = 1'b0;
    localparam logic       KIND_END  = 1'b1;

    typedef logic [1:0] status_t;

    localparam status_t    STATUS_OK        = 2'd0;
    localparam status_t    STATUS_CRC_ERROR = 2'd1;
    localparam status_t    STATUS_COUNT_ERR = 2'd2;

    localparam logic [7:0] FUNC_MAX         = 8'd50;
    localparam logic [5:0] FUNC_READ_HOLD   = 6'd3;
    localparam logic [8:0] DEFAULT_LENGTH   = 9'd8;
    localparam logic [8:0] COUNT_OVERHEAD   = 9'd5;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    localparam logic [7:0] SLAVE_ADDRESS_RESET  = 8'd1;
    localparam logic [6:0] EXPECTED_COUNT_RESET = 7'd1;

    // CRC-16/MODBUS, reflected, one byte per call
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/modbus_rtu_response_receiver_core.sv @@
// A result appears on out_valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_stall is low; the frame state and CRC
// step are computed in one pass between the state registers and the result
// register. in_stall rises only while a result is held and out_stall is high.
// Reset: hunting for the address, slave_address = 1, expected_register_count = 1,
// result register empty.
`default_nettype none

module modbus_rtu_response_receiver_core (
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_we,
    input  wire mbrtu_pkg::cfg_index_t    cfg_index,
    input  wire logic [7:0]               cfg_data,

    input  wire logic                     in_valid,
    output      logic                     in_stall,
    input  wire logic [7:0]               rx_byte,

    output      logic                     out_valid,
    input  wire logic                     out_stall,
    output      logic                     kind,
    output      logic [7:0]               byte_value,
    output      logic [8:0]               byte_index,
    output      logic [1:0]               status,
    output      logic [5:0]               function_code,
    output      logic [8:0]               frame_length
);

    logic [7:0]  slave_addr_reg;
    logic [6:0]  exp_count_reg;

    logic        in_frame_reg,  in_frame_next;
    logic [8:0]  pos_reg,       pos_next;
    logic [8:0]  len_reg,       len_next;
    logic [15:0] crc_reg,       crc_next;
    logic [5:0]  func_reg,      func_next;
    logic [7:0]  count_reg,     count_next;
    logic [7:0]  crc_lo_reg,    crc_lo_next;

    logic        out_valid_reg;
    logic        kind_reg,      kind_next;
    logic [7:0]  value_reg,     value_next;
    logic [8:0]  index_reg,     index_next;
    logic [1:0]  status_reg,    status_next;
    logic [5:0]  fcode_reg,     fcode_next;
    logic [8:0]  flen_reg,      flen_next;
    logic        emit;

    logic        accept;
    logic        bad_func;
    logic [8:0]  idx_plus2;
    logic [8:0]  pos_inc;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign idx_plus2 = pos_reg + 9'd2;
    assign pos_inc   = pos_reg + 9'd1;
    assign bad_func  = in_frame_reg && (pos_reg == 9'd1) &&
                       ((rx_byte == 8'd0) || (rx_byte > mbrtu_pkg::FUNC_MAX));

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        crc_next      = crc_reg;
        func_next     = func_reg;
        count_next    = count_reg;
        crc_lo_next   = crc_lo_reg;
        emit          = 1'b0;
        kind_next     = mbrtu_pkg::KIND_BODY;
        value_next    = rx_byte;
        index_next    = pos_reg;
        status_next   = mbrtu_pkg::STATUS_OK;
        fcode_next    = func_reg;
        flen_next     = len_reg;

        if (in_frame_reg && !bad_func) begin
            if (pos_reg == 9'd1) begin
                func_next = rx_byte[5:0];
                len_next  = mbrtu_pkg::DEFAULT_LENGTH;
            end
            if (pos_reg == 9'd2) begin
                count_next = rx_byte;
                if (func_reg == mbrtu_pkg::FUNC_READ_HOLD)
                    len_next = {1'b0, rx_byte} + mbrtu_pkg::COUNT_OVERHEAD;
            end

            if (idx_plus2 < len_next)
                crc_next = mbrtu_pkg::crc16_feed(crc_reg, rx_byte);
            else if (idx_plus2 == len_next)
                crc_lo_next = rx_byte;

            emit       = 1'b1;
            fcode_next = func_next;
            flen_next  = len_next;

            if (pos_inc >= len_next) begin
                // last byte: CRC high byte arrives now, low byte was saved
                in_frame_next = 1'b0;
                pos_next      = '0;
                kind_next     = mbrtu_pkg::KIND_END;
                value_next    = '0;
                if (crc_lo_reg != crc_reg[7:0] || rx_byte != crc_reg[15:8])
                    status_next = mbrtu_pkg::STATUS_CRC_ERROR;
                else if (func_reg == mbrtu_pkg::FUNC_READ_HOLD &&
                         count_reg != {exp_count_reg, 1'b0})
                    status_next = mbrtu_pkg::STATUS_COUNT_ERR;
            end else begin
                pos_next = pos_inc;
            end
        end else begin
            // hunting, or the function code just aborted the frame
            in_frame_next = 1'b0;
            pos_next      = '0;
            if (rx_byte == slave_addr_reg) begin
                in_frame_next = 1'b1;
                pos_next      = 9'd1;
                len_next      = mbrtu_pkg::DEFAULT_LENGTH;
                crc_next      = mbrtu_pkg::crc16_feed(mbrtu_pkg::CRC_INIT, rx_byte);
                func_next     = '0;
                count_next    = '0;
                crc_lo_next   = '0;
                emit          = 1'b1;
                index_next    = '0;
                fcode_next    = '0;
                flen_next     = mbrtu_pkg::DEFAULT_LENGTH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slave_addr_reg <= mbrtu_pkg::SLAVE_ADDRESS_RESET;
            exp_count_reg  <= mbrtu_pkg::EXPECTED_COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                mbrtu_pkg::REG_SLAVE_ADDRESS:  slave_addr_reg <= cfg_data;
                mbrtu_pkg::REG_EXPECTED_COUNT: exp_count_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            len_reg       <= mbrtu_pkg::DEFAULT_LENGTH;
            crc_reg       <= mbrtu_pkg::CRC_INIT;
            func_reg      <= '0;
            count_reg     <= '0;
            crc_lo_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                in_frame_reg <= in_frame_next;
                pos_reg      <= pos_next;
                len_reg      <= len_next;
                crc_reg      <= crc_next;
                func_reg     <= func_next;
                count_reg    <= count_next;
                crc_lo_reg   <= crc_lo_next;
            end
            if (accept)
                out_valid_reg <= emit;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit) begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            index_reg  <= index_next;
            status_reg <= status_next;
            fcode_reg  <= fcode_next;
            flen_reg   <= flen_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign byte_value    = value_reg;
    assign byte_index    = index_reg;
    assign status        = status_reg;
    assign function_code = fcode_reg;
    assign frame_length  = flen_reg;

endmodule

`default_nettype wire
